>>> hw/rtl/plo_pkg.sv
// ----------------------------------------------------------------------------
// plo_pkg: shared types and constants of the piecewise-linear oscillator
// Field widths, item kinds, sequencer states and default parameter values.
// ----------------------------------------------------------------------------
package plo_pkg;

   // payload field widths
   localparam int KIND_W       = 2;
   localparam int SLOT_W       = 4;
   localparam int TIME_W       = 16;
   localparam int VALUE_W      = 16;
   localparam int FREQ_W       = 24;
   localparam int GAIN_W       = 16;
   localparam int SAMPLE_W     = 16;
   localparam int NUM_POINTS_W = 5;

   // level accumulator (Q8.24) and step quotient
   localparam int ACC_W        = 32;
   localparam int QUO_W        = 32;
   // breakpoint value Q2.14 to level Q8.24
   localparam int LEVEL_SHIFT  = 10;
   // fractional scaling of the step numerator
   localparam int NUM_SHIFT    = 18;
   // product level * gain, Q10.38 before the offset is added
   localparam int PROD_W       = ACC_W + GAIN_W;
   localparam int PROD_FRAC    = 24;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   // defaults for the top level parameters
   localparam int MAX_POINTS_DEFAULT  = 16;
   localparam int SAMPLE_RATE_DEFAULT = 48000;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_TICK    = 2'd0,
      KIND_LOAD    = 2'd1,
      KIND_RESTART = 2'd2
   } plo_kind_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RESTART,
      ST_ONE,
      ST_RDA,
      ST_RDB,
      ST_MUL,
      ST_DIVCHK,
      ST_DIV,
      ST_STEP,
      ST_CMP1,
      ST_CMP2,
      ST_ACC,
      ST_GAIN,
      ST_SAT,
      ST_OUT
   } plo_state_type;

endpackage

>>> hw/rtl/plo_if.sv
// ----------------------------------------------------------------------------
// plo_if: request and response channels of the piecewise-linear oscillator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// request channel: tick, breakpoint load or restart
interface plo_req_if import plo_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic [KIND_W-1:0]          kind;
   logic [SLOT_W-1:0]          point_index;
   logic [TIME_W-1:0]          point_time;
   logic signed [VALUE_W-1:0]  point_value;
   logic [FREQ_W-1:0]          frequency;
   logic signed [GAIN_W-1:0]   amplitude;
   logic signed [VALUE_W-1:0]  offset;

   modport source (
      output valid, kind, point_index, point_time, point_value,
             frequency, amplitude, offset,
      input  ready
   );
   modport sink (
      input  valid, kind, point_index, point_time, point_value,
             frequency, amplitude, offset,
      output ready
   );
endinterface

// response channel: one sample per tick
interface plo_rsp_if import plo_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (
      output valid, sample,
      input  ready
   );
   modport sink (
      input  valid, sample,
      output ready
   );
endinterface

>>> hw/rtl/piecewise_linear_oscillator_top.sv
// A tick with two or more breakpoints runs the bit-serial step divider;
// a segment change adds a second step.
// A zero time span or a saturating step skips the divider.
// One item at a time; reset (synchronous) clears segment, level and count.
// ----------------------------------------------------------------------------
// piecewise_linear_oscillator_top: piecewise-linear waveform generator
// Breakpoint table in a RAM with one write and one read port, sequencer with iterative divider.
// ----------------------------------------------------------------------------
module piecewise_linear_oscillator_top import plo_pkg::*; #(
   parameter int MAX_POINTS     = MAX_POINTS_DEFAULT,
   parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   plo_req_if.sink                 req_bus,
   plo_rsp_if.source               rsp_bus,
   input  logic                    csr_wr_en,
   input  logic [NUM_POINTS_W-1:0] csr_wr_data
);

   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CNT1_W     = CNT_W + 1;
   localparam int SR_W       = $clog2(SAMPLE_RATE_HZ + 1);
   localparam int DEN_W      = TIME_W + SR_W;
   localparam int MAG_PROD_W = VALUE_W + FREQ_W;
   localparam int HI_LSB     = QUO_W - NUM_SHIFT;
   localparam int DV_W       = VALUE_W + 1;
   localparam int CMP_W      = ACC_W + 3;
   localparam int DIV_CNT_W  = $clog2(QUO_W);
   localparam int SUM_W      = PROD_W + 1;
   localparam int Y_W        = SUM_W - PROD_FRAC;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

   // segment after s, wrapping at the active count
   function automatic logic [IDX_W-1:0] next_seg(input logic [IDX_W-1:0] s,
                                                 input logic [CNT_W-1:0] cnt);
      logic [CNT1_W-1:0] s1;
      s1 = CNT1_W'(s) + CNT1_W'(1);
      return (s1 < CNT1_W'(cnt)) ? IDX_W'(s1) : '0;
   endfunction

   // control registers
   plo_state_type                  state_ff, state_in;
   logic [NUM_POINTS_W-1:0]        num_points_ff, num_points_in;
   logic [IDX_W-1:0]               seg_ff, seg_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           second_ff, second_in;
   logic [DIV_CNT_W-1:0]           cnt_ff, cnt_in;

   // payload registers
   logic [FREQ_W-1:0]              freq_ff, freq_in;
   logic signed [GAIN_W-1:0]       amp_ff, amp_in;
   logic signed [VALUE_W-1:0]      off_ff, off_in;
   logic [TIME_W-1:0]              ta_ff, ta_in, tb_ff, tb_in;
   logic signed [VALUE_W-1:0]      va_ff, va_in, vb_ff, vb_in;
   logic                           dtz_ff, dtz_in, neg_ff, neg_in, ovf_ff, ovf_in;
   logic signed [ACC_W-1:0]        dvx_ff, dvx_in;
   logic [MAG_PROD_W-1:0]          mag_prod_ff, mag_prod_in;
   logic [DEN_W-1:0]               den_ff, den_in, rem_ff, rem_in;
   logic [QUO_W-1:0]               numlo_ff, numlo_in, quo_ff, quo_in;
   logic signed [ACC_W-1:0]        step_ff, step_in;
   logic [CMP_W-1:0]               d0_ff, d0_in, d1_ff, d1_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic [SAMPLE_W-1:0]            res_ff, res_in, sample_ff, sample_in;

   // breakpoint memory: {time, value}
   logic [TIME_W+VALUE_W-1:0]      point_mem [MAX_POINTS];
   logic [TIME_W+VALUE_W-1:0]      rd_data_ff;
   logic [IDX_W-1:0]               rd_addr;
   logic                           mem_we;

   // combinational helpers
   logic                           accept;
   logic [CNT_W-1:0]               n_act;
   logic [IDX_W-1:0]               seg_norm;
   logic [TIME_W-1:0]              dt;
   logic signed [DV_W-1:0]         dv;
   logic [VALUE_W-1:0]             mag;
   logic [DEN_W-1:0]               hi;
   logic [DEN_W:0]                 trial, diff;
   logic                           ge;
   logic signed [CMP_W-1:0]        tgt, sd0, sd1;
   logic signed [ACC_W:0]          sum;
   logic signed [SUM_W-1:0]        tsum;
   logic [Y_W-1:0]                 y;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.sample = sample_ff;

   // active breakpoint count and normalised segment
   assign n_act    = (32'(num_points_ff) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                       : CNT_W'(num_points_ff);
   assign seg_norm = (CNT_W'(seg_ff) >= n_act) ? '0 : seg_ff;

   // table write on a load beat to a slot in range
   assign mem_we = accept && (req_bus.kind == KIND_LOAD) &&
                   (32'(req_bus.point_index) < MAX_POINTS);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         point_mem[IDX_W'(req_bus.point_index)] <=
            {req_bus.point_time, req_bus.point_value};
      end
      rd_data_ff <= point_mem[rd_addr];
   end

   // sequencer: next state and datapath
   always_comb begin
      state_in      = state_ff;
      num_points_in = num_points_ff;
      seg_in        = seg_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      second_in     = second_ff;
      cnt_in        = cnt_ff;
      freq_in       = freq_ff;
      amp_in        = amp_ff;
      off_in        = off_ff;
      ta_in         = ta_ff;
      va_in         = va_ff;
      tb_in         = tb_ff;
      vb_in         = vb_ff;
      dtz_in        = dtz_ff;
      neg_in        = neg_ff;
      ovf_in        = ovf_ff;
      dvx_in        = dvx_ff;
      mag_prod_in   = mag_prod_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      numlo_in      = numlo_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      d0_in         = d0_ff;
      d1_in         = d1_ff;
      prod_in       = prod_ff;
      res_in        = res_ff;
      sample_in     = sample_ff;
      rd_addr       = '0;

      dt    = tb_ff - ta_ff;
      dv    = DV_W'(vb_ff) - DV_W'(va_ff);
      mag   = dv[DV_W-1] ? VALUE_W'(-dv) : VALUE_W'(dv);
      hi    = DEN_W'(mag_prod_ff[MAG_PROD_W-1:HI_LSB]);
      trial = {rem_ff, numlo_ff[QUO_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
      tgt   = CMP_W'($signed({vb_ff, {LEVEL_SHIFT{1'b0}}}));
      sd0   = tgt - CMP_W'(acc_ff);
      sd1   = sd0 - CMP_W'(step_ff);
      sum   = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(step_ff);
      tsum  = SUM_W'(prod_ff) + SUM_W'($signed({off_ff, {PROD_FRAC{1'b0}}}));
      y     = tsum[SUM_W-1:PROD_FRAC];

      // configuration write
      if (csr_wr_en) begin
         num_points_in = csr_wr_data;
      end

      // response beat taken
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               freq_in = req_bus.frequency;
               amp_in  = req_bus.amplitude;
               off_in  = req_bus.offset;
               case (req_bus.kind)
                  KIND_RESTART: begin
                     if (n_act == '0) begin
                        acc_in = '0;
                        seg_in = '0;
                     end else begin
                        state_in = ST_RESTART;
                     end
                  end
                  KIND_TICK: begin
                     if (n_act == '0) begin
                        res_in   = '0;
                        state_in = ST_OUT;
                     end else if (n_act == CNT_W'(1)) begin
                        state_in = ST_ONE;
                     end else begin
                        seg_in    = seg_norm;
                        rd_addr   = seg_norm;
                        second_in = 1'b0;
                        state_in  = ST_RDA;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // point 0 has been read
         ST_RESTART: begin
            acc_in   = {{(ACC_W-VALUE_W-LEVEL_SHIFT){rd_data_ff[VALUE_W-1]}},
                        rd_data_ff[VALUE_W-1:0], {LEVEL_SHIFT{1'b0}}};
            seg_in   = '0;
            state_in = ST_IDLE;
         end
         ST_ONE: begin
            res_in   = rd_data_ff[VALUE_W-1:0];
            state_in = ST_OUT;
         end
         // segment start point arrives, fetch the end point
         ST_RDA: begin
            ta_in    = rd_data_ff[TIME_W+VALUE_W-1:VALUE_W];
            va_in    = rd_data_ff[VALUE_W-1:0];
            rd_addr  = next_seg(seg_ff, n_act);
            state_in = ST_RDB;
         end
         ST_RDB: begin
            tb_in    = rd_data_ff[TIME_W+VALUE_W-1:VALUE_W];
            vb_in    = rd_data_ff[VALUE_W-1:0];
            state_in = ST_MUL;
         end
         // numerator and denominator products
         ST_MUL: begin
            mag_prod_in = MAG_PROD_W'(mag) * MAG_PROD_W'(freq_ff);
            den_in      = DEN_W'(dt) * DEN_W'(SAMPLE_RATE_HZ);
            dtz_in      = (dt == '0);
            neg_in      = dv[DV_W-1];
            dvx_in      = {{(ACC_W-DV_W-LEVEL_SHIFT){dv[DV_W-1]}}, dv,
                           {LEVEL_SHIFT{1'b0}}};
            state_in    = ST_DIVCHK;
         end
         // quotient above 32 bits saturates and, like a zero span, skips the divider; else divide
         ST_DIVCHK: begin
            rem_in   = hi;
            numlo_in = {mag_prod_ff[HI_LSB-1:0], {NUM_SHIFT{1'b0}}};
            quo_in   = '0;
            cnt_in   = '0;
            ovf_in   = (hi >= den_ff);
            state_in = (dtz_ff || (hi >= den_ff)) ? ST_STEP : ST_DIV;
         end
         // restoring division, one quotient bit a cycle
         ST_DIV: begin
            rem_in   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_in   = {quo_ff[QUO_W-2:0], ge};
            numlo_in = {numlo_ff[QUO_W-2:0], 1'b0};
            cnt_in   = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_STEP;
            end
         end
         // signed, saturated step
         ST_STEP: begin
            if (dtz_ff) begin
               step_in = dvx_ff;
            end else if (neg_ff) begin
               step_in = (ovf_ff || (quo_ff[QUO_W-1] && (|quo_ff[QUO_W-2:0])))
                         ? ACC_MIN : -quo_ff;
            end else begin
               step_in = (ovf_ff || quo_ff[QUO_W-1]) ? ACC_MAX : quo_ff;
            end
            state_in = second_ff ? ST_ACC : ST_CMP1;
         end
         // distances to the segment end, before and after the step
         ST_CMP1: begin
            d0_in    = sd0[CMP_W-1] ? CMP_W'(-sd0) : CMP_W'(sd0);
            d1_in    = sd1[CMP_W-1] ? CMP_W'(-sd1) : CMP_W'(sd1);
            state_in = ST_CMP2;
         end
         // overshoot moves to the next segment and refetches its end point
         ST_CMP2: begin
            if (d0_ff < d1_ff) begin
               seg_in    = next_seg(seg_ff, n_act);
               ta_in     = tb_ff;
               va_in     = vb_ff;
               rd_addr   = next_seg(next_seg(seg_ff, n_act), n_act);
               second_in = 1'b1;
               state_in  = ST_RDB;
            end else begin
               state_in  = ST_ACC;
            end
         end
         // saturating level update
         ST_ACC: begin
            acc_in   = (sum[ACC_W] != sum[ACC_W-1])
                       ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            prod_in  = PROD_W'(acc_ff) * PROD_W'(amp_ff);
            state_in = ST_SAT;
         end
         // offset, floor to Q2.14, saturate
         ST_SAT: begin
            if ((&y[Y_W-1:SAMPLE_W-1]) || !(|y[Y_W-1:SAMPLE_W-1])) begin
               res_in = y[SAMPLE_W-1:0];
            end else begin
               res_in = y[Y_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
            end
            state_in = ST_OUT;
         end
         // hand the sample to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               sample_in    = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         num_points_ff <= '0;
         seg_ff        <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         second_ff     <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         num_points_ff <= num_points_in;
         seg_ff        <= seg_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
         second_ff     <= second_in;
         cnt_ff        <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      freq_ff     <= freq_in;
      amp_ff      <= amp_in;
      off_ff      <= off_in;
      ta_ff       <= ta_in;
      va_ff       <= va_in;
      tb_ff       <= tb_in;
      vb_ff       <= vb_in;
      dtz_ff      <= dtz_in;
      neg_ff      <= neg_in;
      ovf_ff      <= ovf_in;
      dvx_ff      <= dvx_in;
      mag_prod_ff <= mag_prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      numlo_ff    <= numlo_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      d0_ff       <= d0_in;
      d1_ff       <= d1_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      sample_ff   <= sample_in;
   end

endmodule

>>> hw/rtl/plo_checker.sv
// ----------------------------------------------------------------------------
// plo_checker: port-level checks of the piecewise-linear oscillator
// Bound to the top level; watches the channels only.
// ----------------------------------------------------------------------------
module plo_checker import plo_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [KIND_W-1:0]  req_kind,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_sample
);

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a pending sample holds until taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_sample)))
      else $error("pending sample dropped or changed");

   // loads and restarts give no sample
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind != KIND_TICK) && !rsp_valid)
      |=> !rsp_valid)
      else $error("sample without a tick");

   // an accepted tick makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == KIND_TICK)) |=> !req_ready)
      else $error("new beat accepted during a tick");

endmodule

bind piecewise_linear_oscillator_top plo_checker u_plo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_kind   (req_bus.kind),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_sample (rsp_bus.sample)
);
